// ===== src/tprd_pkg.sv =====
`default_nettype none
package tprd_pkg;

    localparam int TYPE_ENTRIES = 8;

    localparam int BYTE_W  = 8;
    localparam int TABLE_W = 64;
    localparam int COUNT_W = 4;
    localparam int TYPE_W  = 3;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_CODES      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTHS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_COUNT      = 2'd3;

    typedef struct packed {
        logic              found;
        logic [TYPE_W-1:0] hit;
        logic [BYTE_W-1:0] length;
    } t_match;

endpackage
`default_nettype wire

// ===== src/tprd_type_match.sv =====
`default_nettype none
module tprd_type_match (
    input  wire logic [tprd_pkg::BYTE_W-1:0]  i_rx_byte,
    input  wire logic [tprd_pkg::TABLE_W-1:0] i_type_codes,
    input  wire logic [tprd_pkg::TABLE_W-1:0] i_payload_lengths,
    input  wire logic [tprd_pkg::COUNT_W-1:0] i_type_count,
    output tprd_pkg::t_match                  o_match
);
    import tprd_pkg::*;

    logic [COUNT_W-1:0]      eff_count;
    logic [TYPE_ENTRIES-1:0] hits;
    logic                    found;
    logic [TYPE_W-1:0]       hit;

    assign eff_count = (i_type_count > COUNT_W'(TYPE_ENTRIES)) ?
                       COUNT_W'(TYPE_ENTRIES) : i_type_count;

    // one compare per table entry, all in parallel
    always_comb begin
        for (int k = 0; k < TYPE_ENTRIES; k++) begin
            hits[k] = (COUNT_W'(k) < eff_count) &&
                      (i_type_codes[k*BYTE_W +: BYTE_W] == i_rx_byte);
        end
    end

    // lowest matching entry wins
    always_comb begin
        found = 1'b0;
        hit   = '0;
        for (int k = TYPE_ENTRIES - 1; k >= 0; k--) begin
            if (hits[k]) begin
                found = 1'b1;
                hit   = TYPE_W'(k);
            end
        end
    end

    assign o_match.found  = found;
    assign o_match.hit    = hit;
    assign o_match.length = i_payload_lengths[hit*BYTE_W +: BYTE_W];

endmodule
`default_nettype wire

// ===== src/typed_packet_receive_deframer_unit.sv =====
// Each accepted byte's result is registered in the output register.
// Throughput: one byte per cycle; the input is ready whenever the output register
// is empty or being taken in the same cycle.
// Type lookup is a parallel compare over the table, done in the accept cycle.
// Reset (synchronous, active low) clears the configuration registers, the parser
// state and the output valid.
`default_nettype none
module typed_packet_receive_deframer_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [tprd_pkg::BYTE_W-1:0]   i_rx_byte,

    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_payload_valid,
    output logic [tprd_pkg::BYTE_W-1:0]        o_payload_byte,
    output logic [tprd_pkg::BYTE_W-1:0]        o_byte_index,
    output logic [tprd_pkg::TYPE_W-1:0]        o_packet_type,
    output logic                               o_packet_done,

    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [tprd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tprd_pkg::TABLE_W-1:0]  i_cfg_data
);
    import tprd_pkg::*;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_TYPE    = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_END     = 2'd3;

    logic [BYTE_W-1:0]  r_start_code;
    logic [TABLE_W-1:0] r_type_codes;
    logic [TABLE_W-1:0] r_payload_lengths;
    logic [COUNT_W-1:0] r_type_count;

    logic [1:0]         r_phase, n_phase;
    logic [BYTE_W-1:0]  r_left, n_left;
    logic [BYTE_W-1:0]  r_taken, n_taken;
    logic [TYPE_W-1:0]  r_type, n_type;

    logic               r_out_valid;
    logic               r_pvalid, n_pvalid;
    logic [BYTE_W-1:0]  r_pbyte, n_pbyte;
    logic [BYTE_W-1:0]  r_idx, n_idx;
    logic [TYPE_W-1:0]  r_ptype, n_ptype;
    logic               r_done, n_done;

    logic               in_fire;
    logic [BYTE_W-1:0]  left_dec;
    t_match             match;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code      <= '0;
            r_type_codes      <= '0;
            r_payload_lengths <= '0;
            r_type_count      <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_CODE:      r_start_code      <= i_cfg_data[BYTE_W-1:0];
                CFG_TYPE_CODES:      r_type_codes      <= i_cfg_data;
                CFG_PAYLOAD_LENGTHS: r_payload_lengths <= i_cfg_data;
                CFG_TYPE_COUNT:      r_type_count      <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    tprd_type_match u_match (
        .i_rx_byte        (i_rx_byte),
        .i_type_codes     (r_type_codes),
        .i_payload_lengths(r_payload_lengths),
        .i_type_count     (r_type_count),
        .o_match          (match)
    );

    assign left_dec = (r_left != '0) ? r_left - BYTE_W'(1) : '0;

    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_taken  = r_taken;
        n_type   = r_type;
        n_pvalid = 1'b0;
        n_pbyte  = '0;
        n_idx    = '0;
        n_ptype  = '0;
        n_done   = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_rx_byte == r_start_code) begin
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                if (!match.found) begin
                    n_phase = PH_IDLE;
                    n_left  = '0;
                    n_taken = '0;
                    n_type  = '0;
                end else begin
                    n_type  = match.hit;
                    n_taken = '0;
                    n_left  = match.length;
                    if (match.length == '0) begin
                        // empty packet: the type byte closes it
                        n_phase = PH_END;
                        n_done  = 1'b1;
                        n_ptype = match.hit;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_pvalid = 1'b1;
                n_pbyte  = i_rx_byte;
                n_idx    = r_taken;
                n_ptype  = r_type;
                n_taken  = r_taken + BYTE_W'(1);
                n_left   = left_dec;
                if (left_dec == '0) begin
                    n_phase = PH_END;
                    n_done  = 1'b1;
                end
            end
            default: begin
                if (i_rx_byte == r_start_code) begin
                    n_phase = PH_TYPE;
                    n_left  = '0;
                    n_taken = '0;
                    n_type  = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_left      <= '0;
            r_taken     <= '0;
            r_type      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase <= n_phase;
                r_left  <= n_left;
                r_taken <= n_taken;
                r_type  <= n_type;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_pvalid <= n_pvalid;
            r_pbyte  <= n_pbyte;
            r_idx    <= n_idx;
            r_ptype  <= n_ptype;
            r_done   <= n_done;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_payload_valid = r_pvalid;
    assign o_payload_byte  = r_pbyte;
    assign o_byte_index    = r_idx;
    assign o_packet_type   = r_ptype;
    assign o_packet_done   = r_done;

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
module tb;
    import tprd_pkg::*;

    localparam int HOLD_CYCLES = 150;
    localparam int STALL_LIMIT = 1000;

    typedef enum logic [1:0] {SEEK_START, AWAIT_TYPE, IN_PAYLOAD, PKT_ENDED} t_rx_state;

    typedef struct packed {
        logic              pay_valid;
        logic [BYTE_W-1:0] pay_byte;
        logic [BYTE_W-1:0] index;
        logic [TYPE_W-1:0] ptype;
        logic              done;
    } t_deframe_out;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid  = 1'b0;
    logic [BYTE_W-1:0]    rx_byte   = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_START_CODE;
    logic [TABLE_W-1:0]   cfg_data  = '0;

    logic                 o_in_ready, o_out_valid, o_cfg_ready;
    logic                 o_payload_valid, o_packet_done;
    logic [BYTE_W-1:0]    o_payload_byte, o_byte_index;
    logic [TYPE_W-1:0]    o_packet_type;

    typed_packet_receive_deframer_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_rx_byte       (rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_payload_valid (o_payload_valid),
        .o_payload_byte  (o_payload_byte),
        .o_byte_index    (o_byte_index),
        .o_packet_type   (o_packet_type),
        .o_packet_done   (o_packet_done),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // shadow copy of the registers and the parser
    logic [BYTE_W-1:0]  start_code      = '0;
    logic [TABLE_W-1:0] type_codes      = '0;
    logic [TABLE_W-1:0] payload_lengths = '0;
    logic [COUNT_W-1:0] type_count      = '0;
    t_rx_state          rx_state        = SEEK_START;
    logic [BYTE_W-1:0]  bytes_left      = '0;
    logic [BYTE_W-1:0]  bytes_taken     = '0;
    logic [TYPE_W-1:0]  current_type    = '0;

    t_deframe_out expected_results[$];

    int  mismatch_count = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  packets_done = 0;
    int  payload_bytes = 0;
    int  reg_writes = 0;
    bit  tx_no_idle = 1'b0;
    bit  rx_no_idle = 1'b0;
    bit  hold_output = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_deframe_out deframe_byte(input logic [BYTE_W-1:0] c);
        t_deframe_out r;
        int n;
        bit found;
        logic [TYPE_W-1:0] hit;
        r = '0;
        found = 1'b0;
        hit = '0;
        case (rx_state)
            SEEK_START: begin
                if (c == start_code) rx_state = AWAIT_TYPE;
            end
            AWAIT_TYPE: begin
                n = (type_count > TYPE_ENTRIES) ? TYPE_ENTRIES : type_count;
                for (int k = 0; k < n; k++) begin
                    if (!found && type_codes[8*k +: 8] == c) begin
                        found = 1'b1;
                        hit = k[TYPE_W-1:0];
                    end
                end
                if (!found) begin
                    rx_state = SEEK_START;
                    bytes_left = '0;
                    bytes_taken = '0;
                    current_type = '0;
                end else begin
                    current_type = hit;
                    bytes_taken = '0;
                    bytes_left = payload_lengths[8*hit +: 8];
                    if (bytes_left == 0) begin
                        rx_state = PKT_ENDED;
                        r.done = 1'b1;
                        r.ptype = current_type;
                    end else begin
                        rx_state = IN_PAYLOAD;
                    end
                end
            end
            IN_PAYLOAD: begin
                r.pay_valid = 1'b1;
                r.pay_byte = c;
                r.index = bytes_taken;
                r.ptype = current_type;
                bytes_taken = bytes_taken + 1'b1;
                if (bytes_left != 0) bytes_left = bytes_left - 1'b1;
                if (bytes_left == 0) begin
                    rx_state = PKT_ENDED;
                    r.done = 1'b1;
                end
            end
            default: begin
                // after a packet only the start byte matters
                if (c == start_code) begin
                    bytes_left = '0;
                    bytes_taken = '0;
                    current_type = '0;
                    rx_state = AWAIT_TYPE;
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(deframe_byte(b));
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TABLE_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_START_CODE:      start_code = d[BYTE_W-1:0];
            CFG_TYPE_CODES:      type_codes = d;
            CFG_PAYLOAD_LENGTHS: payload_lengths = d;
            default:             type_count = d[COUNT_W-1:0];
        endcase
        reg_writes++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // upper bits of the narrow registers carry junk that must be dropped
    task automatic configure(input logic [BYTE_W-1:0] sc, input logic [TABLE_W-1:0] codes,
                             input logic [TABLE_W-1:0] lens, input logic [COUNT_W-1:0] cnt);
        logic [TABLE_W-1:0] d;
        drain_results();
        d = {$urandom, $urandom};
        d[BYTE_W-1:0] = sc;
        write_reg(CFG_START_CODE, d);
        write_reg(CFG_TYPE_CODES, codes);
        write_reg(CFG_PAYLOAD_LENGTHS, lens);
        d = {$urandom, $urandom};
        d[COUNT_W-1:0] = cnt;
        write_reg(CFG_TYPE_COUNT, d);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_setup(input logic [BYTE_W-1:0] sc, input logic [COUNT_W-1:0] cnt);
        logic [TABLE_W-1:0] lens;
        for (int k = 0; k < TYPE_ENTRIES; k++)
            lens[8*k +: 8] = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
        configure(sc, {$urandom, $urandom}, lens, cnt);
    endtask

    // mostly well-formed packets; the rest are broken packets and line noise
    task automatic random_traffic(input int n_items);
        int sent, pick, n, k, len, n_noise;
        sent = 0;
        n = (type_count > TYPE_ENTRIES) ? TYPE_ENTRIES : type_count;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 72 && n > 0) begin
                k = $urandom_range(0, n - 1);
                len = payload_lengths[8*k +: 8];
                send_byte(start_code);
                send_byte(type_codes[8*k +: 8]);
                repeat (len) send_byte(8'($urandom));
                sent += 2 + len;
            end else if (pick < 80 && n > 0) begin
                // truncated: the next start byte lands inside the payload
                k = $urandom_range(0, n - 1);
                send_byte(start_code);
                send_byte(type_codes[8*k +: 8]);
                sent += 2;
            end else if (pick < 88) begin
                send_byte(start_code);
                send_byte(($urandom_range(0, 3) == 0) ? start_code : 8'($urandom));
                sent += 2;
            end else begin
                n_noise = $urandom_range(1, 3);
                repeat (n_noise) send_byte(8'($urandom));
                sent += n_noise;
            end
        end
    endtask

    task automatic test_directed_cases();
        logic [BYTE_W-1:0] seq[$];
        // entries 3 and 4 share a code: the lower one must win
        configure(8'hA5, 64'h4433_2211_11A5_FF00, 64'h0909_0905_0300_0102, 4'd5);
        seq = '{8'h00, 8'hA5, 8'h00, 8'hA5, 8'hFF, 8'h33, 8'hA5, 8'hA5, 8'hA5,
                8'h77, 8'hA5, 8'h11, 8'h01, 8'h02, 8'h03, 8'hA5, 8'hFF, 8'h80};
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic test_table_limits();
        // oversized count acts as a full table, so entry 7 is reachable
        configure(8'hC3, 64'h5A06_0504_0302_0100, 64'h0100_0000_0000_0000, 4'd15);
        send_byte(8'hC3); send_byte(8'h5A); send_byte(8'hEE);
        send_byte(8'hC3); send_byte(8'h07);
        configure(8'hC3, 64'h5A06_0504_0302_0100, 64'h0100_0000_0000_0000, 4'd0);
        send_byte(8'hC3); send_byte(8'h00);
        configure(8'hC3, 64'h5A06_0504_0302_0100, 64'h0100_0000_0000_0000, 4'd7);
        send_byte(8'hC3); send_byte(8'h5A); send_byte(8'h06);
    endtask

    task automatic test_longest_packet();
        configure(8'h7E, {$urandom, 24'($urandom), 8'h3C}, {$urandom, 24'($urandom), 8'hFF},
                  4'd1);
        send_byte(8'h7E);
        send_byte(8'h3C);
        repeat (255) send_byte(8'($urandom));
        send_byte(8'h7E);
        send_byte(8'h3C);
        repeat (3) send_byte(8'($urandom));
    endtask

    task automatic test_random_settings();
        random_setup(8'h00, 4'd8);
        random_traffic(160);
        random_setup(8'hFF, 4'd1);
        random_traffic(150);
        random_setup(8'($urandom), 4'($urandom_range(2, 7)));
        random_traffic(150);
        random_setup(8'($urandom), 4'($urandom_range(9, 15)));
        random_traffic(150);
        random_setup(8'($urandom), 4'd0);
        random_traffic(40);
        // back-to-back on both sides
        tx_no_idle = 1'b1;
        rx_no_idle = 1'b1;
        random_setup(8'($urandom), 4'd8);
        random_traffic(150);
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    task automatic test_output_stall();
        random_setup(8'($urandom), 4'd8);
        tx_no_idle = 1'b1;
        hold_output = 1'b1;
        random_traffic(60);
        tx_no_idle = 1'b0;
    endtask

    function automatic void check_field(input string what, input logic [BYTE_W-1:0] want,
                                        input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, actual %0h", $time, what, want, got);
            mismatch_count++;
        end
    endfunction

    // result side: random stalls, one long hold on request
    initial begin : result_sink
        int gap;
        t_deframe_out want;
        while (!rst_n) @(posedge i_clk);
        forever begin
            gap = rx_no_idle ? 0 : $urandom_range(0, 13);
            if (hold_output) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_output = 1'b0;
            end else if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: result with none expected, actual valid=%0b byte=%0h done=%0b",
                         $time, o_payload_valid, o_payload_byte, o_packet_done);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("payload_valid", 8'(want.pay_valid), 8'(o_payload_valid));
                check_field("payload_byte", want.pay_byte, o_payload_byte);
                check_field("byte_index", want.index, o_byte_index);
                check_field("packet_type", 8'(want.ptype), 8'(o_packet_type));
                check_field("packet_done", 8'(want.done), 8'(o_packet_done));
                if (want.done) packets_done++;
                if (want.pay_valid) payload_bytes++;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
                (cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_table_limits();
        test_longest_packet();
        test_random_settings();
        test_output_stall();
        drain_results();
        repeat (4) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
            mismatch_count++;
        end
        $display("Run covered %0d bytes in, %0d results checked, %0d register writes.",
                 items_sent, results_seen, reg_writes);
        $display("Packets completed: %0d, payload bytes: %0d, field mismatches: %0d.",
                 packets_done, payload_bytes, mismatch_count);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
